// ----- src/tip_pkg.sv -----
// shared constants and types for the instruction mix profiler
package tip_pkg;

    // per-type counters and the distinct address store
    localparam int NUM_KINDS     = 8;
    localparam int ADDR_CAPACITY = 1024;

    // fixed field widths
    localparam int KIND_W   = 4;
    localparam int ADDR_W   = 48;
    localparam int COUNT_W  = 48;
    localparam int DIST_W   = 11;
    localparam int COST_W   = 4;

    // cost registers, one per costed type
    localparam int COST_REGS   = 5;
    localparam int COST_IDX_W  = $clog2(COST_REGS);
    localparam int CFG_IDX_W   = 3;

    localparam logic [COST_W-1:0] COST_RST_ZERO  = 4'd1;
    localparam logic [COST_W-1:0] COST_RST_ONE   = 4'd2;
    localparam logic [COST_W-1:0] COST_RST_TWO   = 4'd2;
    localparam logic [COST_W-1:0] COST_RST_THREE = 4'd3;
    localparam logic [COST_W-1:0] COST_RST_FOUR  = 4'd1;

    // derived widths
    localparam int KIND_IDX_W = $clog2(NUM_KINDS);
    localparam int IDX_W      = $clog2(ADDR_CAPACITY);
    localparam int CNT_W      = $clog2(ADDR_CAPACITY + 1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // outcome of one address search
    typedef struct packed {
        logic              done;
        logic              first_seen;
        logic              store_full;
        logic [DIST_W-1:0] distinct_total;
    } search_res_t;

endpackage

// ----- src/tip_addr_store.sv -----
// distinct address store with a linear search over one memory read port
module tip_addr_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tip_pkg::ADDR_W-1:0] key,
    output tip_pkg::search_res_t       res
);
    import tip_pkg::*;

    logic [ADDR_W-1:0] seen_mem [ADDR_CAPACITY];
    logic [ADDR_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] key_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CNT_W-1:0]  rd_idx_reg;
    logic [CNT_W-1:0]  rd_idx_next;
    logic              busy_reg;
    logic              busy_next;
    logic              pend_reg;
    logic              pend_next;
    logic              issue;
    logic              hit;
    logic              finish;
    logic              fits;
    logic              store_wr;
    search_res_t       res_reg;
    search_res_t       res_next;

    assign issue    = busy_reg && (rd_idx_reg != count_reg);
    assign hit      = pend_reg && (rd_data_reg == key_reg);
    assign finish   = busy_reg && (hit || (!pend_reg && !issue));
    assign fits     = count_reg < CNT_W'(ADDR_CAPACITY);
    assign store_wr = finish && !hit && fits;

    always_comb
    begin
        busy_next   = busy_reg;
        pend_next   = pend_reg;
        rd_idx_next = rd_idx_reg;
        count_next  = store_wr ? count_reg + 1'b1 : count_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            pend_next   = 1'b0;
            rd_idx_next = '0;
        end
        else if (busy_reg)
        begin
            pend_next   = issue;
            rd_idx_next = issue ? rd_idx_reg + 1'b1 : rd_idx_reg;
            if (finish)
            begin
                busy_next = 1'b0;
                pend_next = 1'b0;
            end
        end
        res_next.done           = finish;
        res_next.first_seen     = !hit;
        res_next.store_full     = !hit && !fits;
        res_next.distinct_total = DIST_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            pend_reg   <= 1'b0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
            res_reg    <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            pend_reg   <= pend_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
            res_reg    <= res_next;
        end
    end

    // store memory, entries below the fill count are the only ones read
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_reg <= key;
        end
        if (issue)
        begin
            rd_data_reg <= seen_mem[rd_idx_reg[IDX_W-1:0]];
        end
        if (store_wr)
        begin
            seen_mem[count_reg[IDX_W-1:0]] <= key_reg;
        end
    end

    assign res = res_reg;

endmodule

// ----- src/trace_instruction_mix_profiler.sv -----
// top level of the instruction mix and footprint profiler
// One record (op_kind, inst_address) is taken per input beat and gives one
// result beat: the updated count for that operation type, the saturating
// cycle estimate, the number of distinct addresses held and two flags
// (first_seen, store_full). Records are handled one at a time. A record with
// a new address is compared against all N distinct addresses already stored
// (at most ADDR_CAPACITY); a match on stored entry j ends the search early.
// The time to a result is set by the address search, which compares one
// stored entry per cycle through the single read port of the store memory.
// The result sits in an output register, so the next record is taken while
// the last result still waits. The address store is tracked by a fill count,
// so there is no clearing pass after reset. Cost registers are written
// through the cfg beat channel, which is always ready; writes to indexes past
// the last cost register are dropped. Counters stop at all ones.
module trace_instruction_mix_profiler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tip_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tip_pkg::COST_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tip_pkg::KIND_W-1:0]    op_kind,
    input  logic [tip_pkg::ADDR_W-1:0]    inst_address,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tip_pkg::COUNT_W-1:0]   kind_total,
    output logic [tip_pkg::COUNT_W-1:0]   cycle_sum,
    output logic [tip_pkg::DIST_W-1:0]    distinct_total,
    output logic                          first_seen,
    output logic                          store_full
);
    import tip_pkg::*;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;   // waiting for a record
    localparam logic [1:0] ST_KIND = 2'd1;   // per-type counter write-back
    localparam logic [1:0] ST_WAIT = 2'd2;   // address search running
    localparam logic [1:0] ST_DONE = 2'd3;   // result waits for the output register

    logic [1:0]          state_reg;
    logic [1:0]          state_next;

    // cost registers
    logic [COST_W-1:0]   cost_reg [COST_REGS];

    // per-type counters: small memory with valid bits standing in for reset
    logic [COUNT_W-1:0]  kind_mem [NUM_KINDS];
    logic [NUM_KINDS-1:0] kind_vld_reg;
    logic [COUNT_W-1:0]  kind_rd_reg;
    logic                kind_rd_vld_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic                kind_in_range_reg;
    logic [COUNT_W-1:0]  kind_base;
    logic [COUNT_W-1:0]  kind_inc;
    logic [COUNT_W-1:0]  kind_total_hold_reg;

    // running cycle estimate
    logic [COUNT_W-1:0]  cycle_accum_reg;
    logic [COUNT_W-1:0]  cycle_accum_next;
    logic [COUNT_W:0]    cycle_wide;
    logic [COST_W-1:0]   cost_sel;

    // address search
    logic                in_beat;
    search_res_t         srch_res;
    search_res_t         srch_hold_reg;

    // output register
    logic                out_valid_reg;
    logic                out_load;
    logic [COUNT_W-1:0]  kind_total_reg;
    logic [COUNT_W-1:0]  cycle_sum_reg;
    logic [DIST_W-1:0]   distinct_total_reg;
    logic                first_seen_reg;
    logic                store_full_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_beat   = in_valid && in_ready;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    tip_addr_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_beat),
        .key   (inst_address),
        .res   (srch_res)
    );

    // read-modify-write of the per-type counter, saturating at all ones
    always_comb
    begin
        kind_base = kind_rd_vld_reg ? kind_rd_reg : '0;
        kind_inc  = (kind_base == COUNT_MAX) ? kind_base : kind_base + 1'b1;
    end

    // types past the last cost register cost nothing
    always_comb
    begin
        cost_sel         = (kind_reg < COST_REGS) ? cost_reg[kind_reg[COST_IDX_W-1:0]] : '0;
        cycle_wide       = {1'b0, cycle_accum_reg} + (COUNT_W + 1)'(cost_sel);
        cycle_accum_next = cycle_wide[COUNT_W] ? COUNT_MAX : cycle_wide[COUNT_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = ST_KIND;
                end
            end
            ST_KIND:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (srch_res.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            kind_vld_reg    <= '0;
            cycle_accum_reg <= '0;
            out_valid_reg   <= 1'b0;
            cost_reg[0]     <= COST_RST_ZERO;
            cost_reg[1]     <= COST_RST_ONE;
            cost_reg[2]     <= COST_RST_TWO;
            cost_reg[3]     <= COST_RST_THREE;
            cost_reg[4]     <= COST_RST_FOUR;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready && (cfg_index < COST_REGS))
            begin
                cost_reg[cfg_index[COST_IDX_W-1:0]] <= cfg_data;
            end
            if (state_reg == ST_KIND)
            begin
                cycle_accum_reg <= cycle_accum_next;
                if (kind_in_range_reg)
                begin
                    kind_vld_reg[kind_reg[KIND_IDX_W-1:0]] <= 1'b1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // counter memory and payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            kind_reg          <= op_kind;
            kind_in_range_reg <= (op_kind < NUM_KINDS);
            kind_rd_reg       <= kind_mem[op_kind[KIND_IDX_W-1:0]];
            kind_rd_vld_reg   <= kind_vld_reg[op_kind[KIND_IDX_W-1:0]];
        end
        if (state_reg == ST_KIND)
        begin
            if (kind_in_range_reg)
            begin
                kind_mem[kind_reg[KIND_IDX_W-1:0]] <= kind_inc;
                kind_total_hold_reg <= kind_inc;
            end
            else
            begin
                kind_total_hold_reg <= '0;
            end
        end
        if ((state_reg == ST_WAIT) && srch_res.done)
        begin
            srch_hold_reg <= srch_res;
        end
        if (out_load)
        begin
            kind_total_reg     <= kind_total_hold_reg;
            cycle_sum_reg      <= cycle_accum_reg;
            distinct_total_reg <= srch_hold_reg.distinct_total;
            first_seen_reg     <= srch_hold_reg.first_seen;
            store_full_reg     <= srch_hold_reg.store_full;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind_total     = kind_total_reg;
    assign cycle_sum      = cycle_sum_reg;
    assign distinct_total = distinct_total_reg;
    assign first_seen     = first_seen_reg;
    assign store_full     = store_full_reg;

`ifndef SYNTHESIS
    // a search only finishes while the sequencer waits for it
    a_search_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        srch_res.done |-> (state_reg == ST_WAIT))
        else $error("address search finished outside the wait state");

    // an accepted record always goes to the counter write-back next
    a_beat_to_kind: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg == ST_KIND))
        else $error("record beat not followed by counter write-back");

    // a full store is only reported for an address not found
    a_full_means_new: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(store_full_reg && !first_seen_reg))
        else $error("store full flagged for a known address");

    // the distinct count never passes the store capacity
    a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (distinct_total_reg <= ADDR_CAPACITY))
        else $error("distinct count beyond store capacity");
`endif

endmodule
